// ===== rtl/cac_pkg.sv =====
package cac_pkg;

   localparam int DIM_W   = 13;
   localparam int CNT_W   = 12;
   localparam int CELL_W  = 8;
   localparam int GRID_W  = 9;
   localparam int CHAN_W  = 8;
   localparam int COLOR_W = 24;
   localparam int MODE_W  = 2;
   localparam int ADDR_W  = 5;
   localparam int DATA_W  = 32;

   localparam logic [DIM_W-1:0]  MAX_DIMENSION = 13'd4096;
   localparam logic [GRID_W-1:0] MAX_GRID      = 9'd256;
   localparam logic [CHAN_W-1:0] FULL_ALPHA    = 8'd255;

   localparam logic [DIM_W-1:0]   RESET_WIDTH  = 13'd256;
   localparam logic [DIM_W-1:0]   RESET_HEIGHT = 13'd256;
   localparam logic [GRID_W-1:0]  RESET_GRID   = 9'd8;
   localparam logic [COLOR_W-1:0] RESET_FRONT  = 24'hFFFFFF;
   localparam logic [COLOR_W-1:0] RESET_BACK   = 24'hC8C8C8;

   // register indexes (byte address / 4)
   localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
   localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
   localparam logic [2:0] REG_GRID_SIZE    = 3'd2;
   localparam logic [2:0] REG_FRONT_COLOR  = 3'd3;
   localparam logic [2:0] REG_BACK_COLOR   = 3'd4;
   localparam logic [2:0] REG_VIEW_MODE    = 3'd5;

   // view modes; the unused code falls back to composite
   localparam logic [MODE_W-1:0] MODE_COMPOSITE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_COLOR     = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ALPHA     = 2'd2;

   // clamped configuration as used by the datapath
   typedef struct packed {
      logic [DIM_W-1:0]   width;
      logic [DIM_W-1:0]   height;
      logic [GRID_W-1:0]  grid;
      logic [COLOR_W-1:0] front_color;
      logic [COLOR_W-1:0] back_color;
      logic [MODE_W-1:0]  view_mode;
   } cfg_type;

   typedef struct packed {
      logic checker_odd;
      logic frame_end;
   } pos_type;

   // floor(x / 255) for x up to 65025
   function automatic logic [CHAN_W-1:0] div255(input logic [15:0] x);
      logic [16:0] t;
      t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
      return t[15:8];
   endfunction

endpackage

// ===== rtl/cac_csr.sv =====
module cac_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [cac_pkg::ADDR_W-1:0]    csr_paddr,
   input  logic [cac_pkg::DATA_W-1:0]    csr_pwdata,
   output logic [cac_pkg::DATA_W-1:0]    csr_prdata,
   output logic                          csr_pready,
   output cac_pkg::cfg_type              cfg
);

   logic [cac_pkg::DIM_W-1:0]   width_ff;
   logic [cac_pkg::DIM_W-1:0]   height_ff;
   logic [cac_pkg::GRID_W-1:0]  grid_ff;
   logic [cac_pkg::COLOR_W-1:0] front_ff;
   logic [cac_pkg::COLOR_W-1:0] back_ff;
   logic [cac_pkg::MODE_W-1:0]  mode_ff;
   logic [2:0]                  index;
   logic                        wr_en;

   assign csr_pready = 1'b1;
   assign index      = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= cac_pkg::RESET_WIDTH;
         height_ff <= cac_pkg::RESET_HEIGHT;
         grid_ff   <= cac_pkg::RESET_GRID;
         front_ff  <= cac_pkg::RESET_FRONT;
         back_ff   <= cac_pkg::RESET_BACK;
         mode_ff   <= cac_pkg::MODE_COMPOSITE;
      end else if (wr_en) begin
         case (index)
            cac_pkg::REG_FRAME_WIDTH:  width_ff  <= csr_pwdata[cac_pkg::DIM_W-1:0];
            cac_pkg::REG_FRAME_HEIGHT: height_ff <= csr_pwdata[cac_pkg::DIM_W-1:0];
            cac_pkg::REG_GRID_SIZE:    grid_ff   <= csr_pwdata[cac_pkg::GRID_W-1:0];
            cac_pkg::REG_FRONT_COLOR:  front_ff  <= csr_pwdata[cac_pkg::COLOR_W-1:0];
            cac_pkg::REG_BACK_COLOR:   back_ff   <= csr_pwdata[cac_pkg::COLOR_W-1:0];
            cac_pkg::REG_VIEW_MODE:    mode_ff   <= csr_pwdata[cac_pkg::MODE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         cac_pkg::REG_FRAME_WIDTH:  csr_prdata = {19'd0, width_ff};
         cac_pkg::REG_FRAME_HEIGHT: csr_prdata = {19'd0, height_ff};
         cac_pkg::REG_GRID_SIZE:    csr_prdata = {23'd0, grid_ff};
         cac_pkg::REG_FRONT_COLOR:  csr_prdata = {8'd0, front_ff};
         cac_pkg::REG_BACK_COLOR:   csr_prdata = {8'd0, back_ff};
         cac_pkg::REG_VIEW_MODE:    csr_prdata = {30'd0, mode_ff};
         default:                   csr_prdata = '0;
      endcase
   end

   // zero reads as one, oversize saturates
   always_comb begin
      cfg.width = width_ff;
      if (width_ff == '0)
         cfg.width = 13'd1;
      else if (width_ff > cac_pkg::MAX_DIMENSION)
         cfg.width = cac_pkg::MAX_DIMENSION;
      cfg.height = height_ff;
      if (height_ff == '0)
         cfg.height = 13'd1;
      else if (height_ff > cac_pkg::MAX_DIMENSION)
         cfg.height = cac_pkg::MAX_DIMENSION;
      cfg.grid = grid_ff;
      if (grid_ff == '0)
         cfg.grid = 9'd1;
      else if (grid_ff > cac_pkg::MAX_GRID)
         cfg.grid = cac_pkg::MAX_GRID;
      cfg.front_color = front_ff;
      cfg.back_color  = back_ff;
      cfg.view_mode   = mode_ff;
   end

endmodule

// ===== rtl/cac_raster.sv =====
module cac_raster (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  cac_pkg::cfg_type cfg,
   output cac_pkg::pos_type pos
);

   logic [cac_pkg::CNT_W-1:0]  col_ff, col_in;
   logic [cac_pkg::CNT_W-1:0]  row_ff, row_in;
   logic [cac_pkg::CELL_W-1:0] col_cell_ff, col_cell_in;
   logic [cac_pkg::CELL_W-1:0] row_cell_ff, row_cell_in;
   logic                       col_par_ff, col_par_in;
   logic                       row_par_ff, row_par_in;
   logic                       last_col, last_row;
   logic                       col_cell_wrap, row_cell_wrap;

   assign last_col      = ({1'b0, col_ff} + 13'd1) >= cfg.width;
   assign last_row      = ({1'b0, row_ff} + 13'd1) >= cfg.height;
   assign col_cell_wrap = ({1'b0, col_cell_ff} + 9'd1) >= cfg.grid;
   assign row_cell_wrap = ({1'b0, row_cell_ff} + 9'd1) >= cfg.grid;

   assign pos.checker_odd = col_par_ff ^ row_par_ff;
   assign pos.frame_end   = last_col && last_row;

   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      col_cell_in = col_cell_ff;
      row_cell_in = row_cell_ff;
      col_par_in  = col_par_ff;
      row_par_in  = row_par_ff;
      if (!last_col) begin
         col_in = col_ff + 12'd1;
         if (col_cell_wrap) begin
            col_cell_in = '0;
            col_par_in  = ~col_par_ff;
         end else begin
            col_cell_in = col_cell_ff + 8'd1;
         end
      end else begin
         col_in      = '0;
         col_cell_in = '0;
         col_par_in  = 1'b0;
         if (!last_row) begin
            row_in = row_ff + 12'd1;
            if (row_cell_wrap) begin
               row_cell_in = '0;
               row_par_in  = ~row_par_ff;
            end else begin
               row_cell_in = row_cell_ff + 8'd1;
            end
         end else begin
            row_in      = '0;
            row_cell_in = '0;
            row_par_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         col_cell_ff <= '0;
         row_cell_ff <= '0;
         col_par_ff  <= 1'b0;
         row_par_ff  <= 1'b0;
      end else if (advance) begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         col_cell_ff <= col_cell_in;
         row_cell_ff <= row_cell_in;
         col_par_ff  <= col_par_in;
         row_par_ff  <= row_par_in;
      end
   end

endmodule

// ===== rtl/cac_blend.sv =====
module cac_blend (
   input  logic [cac_pkg::MODE_W-1:0]  view_mode,
   input  logic [cac_pkg::CHAN_W-1:0]  src_red,
   input  logic [cac_pkg::CHAN_W-1:0]  src_green,
   input  logic [cac_pkg::CHAN_W-1:0]  src_blue,
   input  logic [cac_pkg::CHAN_W-1:0]  src_alpha,
   input  logic [cac_pkg::COLOR_W-1:0] tile_color,
   output logic [cac_pkg::CHAN_W-1:0]  pix_red,
   output logic [cac_pkg::CHAN_W-1:0]  pix_green,
   output logic [cac_pkg::CHAN_W-1:0]  pix_blue
);

   logic [cac_pkg::CHAN_W-1:0] inv_alpha;
   logic [15:0]                sum_red, sum_green, sum_blue;

   assign inv_alpha = cac_pkg::FULL_ALPHA - src_alpha;

   // s*a + c*(255-a) never exceeds 255*255
   assign sum_red   = ({8'd0, src_red} * {8'd0, src_alpha})
                    + ({8'd0, tile_color[23:16]} * {8'd0, inv_alpha});
   assign sum_green = ({8'd0, src_green} * {8'd0, src_alpha})
                    + ({8'd0, tile_color[15:8]} * {8'd0, inv_alpha});
   assign sum_blue  = ({8'd0, src_blue} * {8'd0, src_alpha})
                    + ({8'd0, tile_color[7:0]} * {8'd0, inv_alpha});

   always_comb begin
      case (view_mode)
         cac_pkg::MODE_COLOR: begin
            pix_red   = src_red;
            pix_green = src_green;
            pix_blue  = src_blue;
         end
         cac_pkg::MODE_ALPHA: begin
            pix_red   = src_alpha;
            pix_green = src_alpha;
            pix_blue  = src_alpha;
         end
         default: begin
            pix_red   = cac_pkg::div255(sum_red);
            pix_green = cac_pkg::div255(sum_green);
            pix_blue  = cac_pkg::div255(sum_blue);
         end
      endcase
   end

endmodule

// ===== rtl/checker_alpha_composite.sv =====
// Alpha blend of a raster RGBA stream over a checkerboard.
// Stages: input register, blend logic, output register, ahead of rsp_valid.
// Throughput: one pixel per cycle unless rsp_ready stalls the output register.
// Reset (synchronous, active high): raster position and pipeline valids cleared,
// configuration registers back to 256x256 frame, 8 pixel cells, white/gray, composite.
module checker_alpha_composite (
   input  logic                       clock,
   input  logic                       reset,
   // pixel input
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [cac_pkg::CHAN_W-1:0] req_source_red,
   input  logic [cac_pkg::CHAN_W-1:0] req_source_green,
   input  logic [cac_pkg::CHAN_W-1:0] req_source_blue,
   input  logic [cac_pkg::CHAN_W-1:0] req_source_alpha,
   // displayed pixel
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [cac_pkg::CHAN_W-1:0] rsp_out_red,
   output logic [cac_pkg::CHAN_W-1:0] rsp_out_green,
   output logic [cac_pkg::CHAN_W-1:0] rsp_out_blue,
   output logic                       rsp_frame_end,
   // register port
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [cac_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [cac_pkg::DATA_W-1:0] csr_pwdata,
   output logic [cac_pkg::DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   cac_pkg::cfg_type cfg;
   cac_pkg::pos_type pos;

   // input stage: pixel plus the checker color and end flag of its position
   logic                        s1_valid_ff;
   logic [cac_pkg::CHAN_W-1:0]  s1_red_ff, s1_green_ff, s1_blue_ff, s1_alpha_ff;
   logic [cac_pkg::COLOR_W-1:0] s1_checker_ff, s1_checker_in;
   logic                        s1_last_ff;

   // output stage
   logic                        rsp_valid_ff;
   logic [cac_pkg::CHAN_W-1:0]  rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic                        rsp_last_ff;
   logic [cac_pkg::CHAN_W-1:0]  pix_red_in, pix_green_in, pix_blue_in;

   logic req_take;
   logic s1_move;

   // stage 1 moves forward when the output register is empty or being drained;
   // the input side keeps streaming as long as stage 1 is free or moving
   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_move;
   assign req_take  = req_valid && req_ready;

   cac_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // raster counters step once per accepted transaction
   cac_raster u_raster (
      .clock   (clock),
      .reset   (reset),
      .advance (req_take),
      .cfg     (cfg),
      .pos     (pos)
   );

   assign s1_checker_in = pos.checker_odd ? cfg.back_color : cfg.front_color;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_red_ff     <= req_source_red;
         s1_green_ff   <= req_source_green;
         s1_blue_ff    <= req_source_blue;
         s1_alpha_ff   <= req_source_alpha;
         s1_checker_ff <= s1_checker_in;
         s1_last_ff    <= pos.frame_end;
      end
   end

   // user must change view mode only with the pipeline empty; not enforced, it is read live
   cac_blend u_blend (
      .view_mode  (cfg.view_mode),
      .src_red    (s1_red_ff),
      .src_green  (s1_green_ff),
      .src_blue   (s1_blue_ff),
      .src_alpha  (s1_alpha_ff),
      .tile_color (s1_checker_ff),
      .pix_red    (pix_red_in),
      .pix_green  (pix_green_in),
      .pix_blue   (pix_blue_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_ready) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_red_ff   <= pix_red_in;
         rsp_green_ff <= pix_green_in;
         rsp_blue_ff  <= pix_blue_in;
         rsp_last_ff  <= s1_last_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = rsp_red_ff;
   assign rsp_out_green = rsp_green_ff;
   assign rsp_out_blue  = rsp_blue_ff;
   assign rsp_frame_end = rsp_last_ff;

endmodule
